>>> sv/cipher_key_square_builder_assert.svh
// assertion macros for the key square builder checker
// no dependencies; included by the checker file only
`ifndef CIPHER_KEY_SQUARE_BUILDER_ASSERT_SVH
`define CIPHER_KEY_SQUARE_BUILDER_ASSERT_SVH

// property that must hold at every edge out of reset
`define CKEY_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("ckey check failed");

// antecedent in this cycle implies consequent in the next
`define CKEY_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ckey check failed");

`endif

>>> sv/ckey_pkg.sv
// shared types, constants and cell position functions for the key square builder
// no dependencies
package ckey_pkg;

  localparam int unsigned Letters = 26;
  localparam int unsigned Cells   = 25;
  localparam int unsigned Side    = 5;
  localparam int unsigned LetterJ = 9;

  typedef logic [4:0] letter_t;
  typedef logic [4:0] cell_t;
  typedef logic [2:0] pos_t;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_FILL   = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_ADD  = 7'b0000010,
    ST_FILL = 7'b0000100,
    ST_LKA  = 7'b0001000,
    ST_LKB  = 7'b0010000,
    ST_LKO1 = 7'b0100000,
    ST_LKO2 = 7'b1000000
  } state_e;

  // one write and one read port of the cell store
  typedef struct packed {
    logic    we;
    letter_t waddr;
    cell_t   wdata;
    logic    re;
    letter_t raddr;
  } mem_req_t;

  function automatic pos_t cell_row(cell_t c);
    pos_t r;
    if (c >= cell_t'(4 * Side)) begin
      r = 3'd4;
    end else if (c >= cell_t'(3 * Side)) begin
      r = 3'd3;
    end else if (c >= cell_t'(2 * Side)) begin
      r = 3'd2;
    end else if (c >= cell_t'(Side)) begin
      r = 3'd1;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

  function automatic pos_t cell_col(cell_t c);
    cell_t base;
    cell_t rem;
    base = cell_t'(cell_row(c)) * cell_t'(Side);
    rem  = c - base;
    return rem[2:0];
  endfunction

endpackage

>>> sv/ckey_mem.sv
// cell store: cell index of each placed letter, one write and one registered read
// depends on ckey_pkg
module ckey_mem (
  input  logic               clk_i,
  input  ckey_pkg::mem_req_t req_i,
  output ckey_pkg::cell_t    rdata_o
);

  ckey_pkg::cell_t mem_q [ckey_pkg::Letters];
  ckey_pkg::cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/ckey_ctrl.sv
// sequencer for add, fill and lookup, used-letter set, fill count and output register
// depends on ckey_pkg; drives the cell store in ckey_mem
module ckey_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        out_data_o,
  output logic               out_last_o,
  output ckey_pkg::mem_req_t mem_req_o,
  input  ckey_pkg::cell_t    rdata_i
);

  ckey_pkg::state_e  state_q, state_d;
  ckey_pkg::letter_t a_q, a_d, b_q, b_d, scan_q, scan_d;
  ckey_pkg::cell_t   filled_q, filled_d, ca_q, ca_d;
  logic [ckey_pkg::Letters-1:0] used_q, used_d;
  logic ha_q, ha_d, hb_q, hb_d;
  logic ov_q, ov_d, ol_q, ol_d;
  logic [15:0] od_q, od_d;

  logic out_free, full, a_ok, b_ok, used_a, used_b, b_first;
  logic emit, e_last, place;
  ckey_pkg::letter_t e_let, p_let;
  ckey_pkg::cell_t   e_cell;
  ckey_pkg::action_e act;

  assign out_free = !ov_q || out_ready_i;
  assign full     = filled_q == ckey_pkg::cell_t'(ckey_pkg::Cells);
  assign a_ok     = a_q < ckey_pkg::letter_t'(ckey_pkg::Letters);
  assign b_ok     = b_q < ckey_pkg::letter_t'(ckey_pkg::Letters);
  assign used_a   = a_ok && used_q[a_q];
  assign used_b   = b_ok && used_q[b_q];
  assign act      = ckey_pkg::action_e'(in_data_i[1:0]);
  // data register holds the second letter's cell during the output states
  assign b_first  = hb_q && (!ha_q || (ca_q > rdata_i));

  always_comb begin
    state_d   = state_q;
    a_d       = a_q;
    b_d       = b_q;
    scan_d    = scan_q;
    filled_d  = filled_q;
    ca_d      = ca_q;
    used_d    = used_q;
    ha_d      = ha_q;
    hb_d      = hb_q;
    in_ready_o = 1'b0;
    emit      = 1'b0;
    e_last    = 1'b0;
    e_let     = a_q;
    e_cell    = filled_q;
    place     = 1'b0;
    p_let     = a_q;
    mem_req_o = '0;

    case (state_q)
      ckey_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          a_d    = in_data_i[6:2];
          b_d    = in_data_i[11:7];
          scan_d = '0;
          case (act)
            ckey_pkg::ACT_ADD:    state_d = ckey_pkg::ST_ADD;
            ckey_pkg::ACT_FILL:   state_d = ckey_pkg::ST_FILL;
            ckey_pkg::ACT_LOOKUP: state_d = ckey_pkg::ST_LKA;
            default:              state_d = ckey_pkg::ST_IDLE;
          endcase
        end
      end
      ckey_pkg::ST_ADD: begin
        if (!a_ok || a_q == ckey_pkg::letter_t'(ckey_pkg::LetterJ) || used_a || full) begin
          state_d = ckey_pkg::ST_IDLE;
        end else if (out_free) begin
          place   = 1'b1;
          emit    = 1'b1;
          e_last  = 1'b1;
          state_d = ckey_pkg::ST_IDLE;
        end
      end
      ckey_pkg::ST_FILL: begin
        // the square fills up exactly when every letter but j is used
        if (full) begin
          state_d = ckey_pkg::ST_IDLE;
        end else if (scan_q == ckey_pkg::letter_t'(ckey_pkg::LetterJ) || used_q[scan_q]) begin
          scan_d = scan_q + 5'd1;
        end else if (out_free) begin
          place  = 1'b1;
          p_let  = scan_q;
          emit   = 1'b1;
          e_let  = scan_q;
          e_last = filled_q == ckey_pkg::cell_t'(ckey_pkg::Cells - 1);
          scan_d = scan_q + 5'd1;
          if (e_last) begin
            state_d = ckey_pkg::ST_IDLE;
          end
        end
      end
      ckey_pkg::ST_LKA: begin
        ha_d = used_a;
        hb_d = used_b && (b_q != a_q);
        mem_req_o.re    = used_a;
        mem_req_o.raddr = a_q;
        if (!used_a && !(used_b && (b_q != a_q))) begin
          state_d = ckey_pkg::ST_IDLE;
        end else begin
          state_d = ckey_pkg::ST_LKB;
        end
      end
      ckey_pkg::ST_LKB: begin
        ca_d            = rdata_i;
        mem_req_o.re    = hb_q;
        mem_req_o.raddr = b_q;
        state_d         = ckey_pkg::ST_LKO1;
      end
      ckey_pkg::ST_LKO1: begin
        if (out_free) begin
          emit   = 1'b1;
          e_let  = b_first ? b_q : a_q;
          e_cell = b_first ? rdata_i : ca_q;
          e_last = !(ha_q && hb_q);
          state_d = (ha_q && hb_q) ? ckey_pkg::ST_LKO2 : ckey_pkg::ST_IDLE;
        end
      end
      ckey_pkg::ST_LKO2: begin
        if (out_free) begin
          emit    = 1'b1;
          e_let   = b_first ? a_q : b_q;
          e_cell  = b_first ? ca_q : rdata_i;
          e_last  = 1'b1;
          state_d = ckey_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ckey_pkg::ST_IDLE;
      end
    endcase

    // writes happen only in add and fill, reads only in lookup: no overlap
    if (place) begin
      mem_req_o.we    = 1'b1;
      mem_req_o.waddr = p_let;
      mem_req_o.wdata = filled_q;
      used_d          = used_q | (ckey_pkg::Letters'(1) << p_let);
      filled_d        = filled_q + 5'd1;
    end
  end

  always_comb begin
    ov_d = ov_q;
    od_d = od_q;
    ol_d = ol_q;
    if (emit) begin
      ov_d = 1'b1;
      od_d = {5'd0, ckey_pkg::cell_col(e_cell), ckey_pkg::cell_row(e_cell), e_let};
      ol_d = e_last;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ckey_pkg::ST_IDLE;
      used_q   <= '0;
      filled_q <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      filled_q <= filled_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    scan_q <= scan_d;
    ca_q   <= ca_d;
    ha_q   <= ha_d;
    hb_q   <= hb_d;
    od_q   <= od_d;
    ol_q   <= ol_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
  assign out_last_o  = ol_q;

endmodule

>>> sv/cipher_key_square_builder.sv
// Add: idle takes the input and the add state registers the result; lookup reads the cells in
// LKA and LKB, then emits from LKO1 and, if both letters are placed, from LKO2; fill scans
// one letter per cycle while the output is free. Throughput: one item at a time; lookup rate
// is set by the single read port of the cell store, fill rate by the one-letter-per-cycle scan.
// Reset (rst_ni low, asynchronous): used letters and fill count cleared, output empty;
// the cell store is not cleared and is read only for letters already placed.
// top level: key square builder; depends on ckey_pkg, ckey_ctrl, ckey_mem
module cipher_key_square_builder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // action[1:0], letter[6:2], second_letter[11:7]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // placed_letter[4:0], row[7:5], column[10:8]
  output logic        m_axis_tlast_o
);

  ckey_pkg::mem_req_t mem_req;
  ckey_pkg::cell_t    mem_rdata;

  ckey_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (s_axis_tdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .mem_req_o   (mem_req),
    .rdata_i     (mem_rdata)
  );

  ckey_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule

>>> sv/ckey_checker.sv
// port-level checks for the key square builder, bound to the top level
// depends on ckey_pkg and cipher_key_square_builder_assert.svh
`include "cipher_key_square_builder_assert.svh"

module ckey_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [15:0] s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  ckey_pkg::letter_t res_letter;
  ckey_pkg::pos_t    res_row;
  ckey_pkg::pos_t    res_col;
  logic [16:0]       res_bus;
  logic              cell_ok;
  logic              out_stall;
  logic              in_real;

  assign res_letter = m_axis_tdata_o[4:0];
  assign res_row    = m_axis_tdata_o[7:5];
  assign res_col    = m_axis_tdata_o[10:8];
  assign res_bus    = {m_axis_tlast_o, m_axis_tdata_o};
  assign cell_ok    = res_row <= 3'd4 && res_col <= 3'd4
                      && res_letter < ckey_pkg::letter_t'(ckey_pkg::Letters)
                      && res_letter != ckey_pkg::letter_t'(ckey_pkg::LetterJ);
  assign out_stall  = m_axis_tvalid_o && !m_axis_tready_i;
  assign in_real    = s_axis_tvalid_i && s_axis_tready_o
                      && s_axis_tdata_i[1:0] != ckey_pkg::ACT_NONE;

  // reported cells lie inside the square and never hold j
  `CKEY_ASSERT(a_cell_range, clk_i, rst_ni, !m_axis_tvalid_o || cell_ok)
  // a stalled result holds
  `CKEY_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid_o && $stable(res_bus))
  // a real action keeps the input closed in the next cycle
  `CKEY_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_real, !s_axis_tready_o)
  // padding bits of the result stay zero
  `CKEY_ASSERT(a_pad_zero, clk_i, rst_ni, !m_axis_tvalid_o || m_axis_tdata_o[15:11] == 5'd0)

endmodule

bind cipher_key_square_builder ckey_checker u_ckey_checker (.*);

>>> tb/tb.sv
// testbench for cipher_key_square_builder: streamed add, fill and lookup transfers
// checked against a scoreboard that mirrors the key square state
// depends on ckey_pkg and the cipher_key_square_builder rtl
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    ckey_pkg::letter_t letter;
    ckey_pkg::pos_t    row;
    ckey_pkg::pos_t    col;
    logic              last;
  } cell_report_t;

  // mirrors the square and holds the cell reports still owed by the block
  class key_square_scoreboard;
    bit [ckey_pkg::Letters-1:0] used;
    int unsigned                cell_of [ckey_pkg::Letters];
    int unsigned                filled;
    cell_report_t               pending [$];
    int                         errors;
    int                         n_inputs;
    int                         n_results;
    int                         max_burst;

    function new();
      used      = '0;
      filled    = 0;
      errors    = 0;
      n_inputs  = 0;
      n_results = 0;
      max_burst = 0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    function bit placed(int unsigned l);
      return l < ckey_pkg::Letters && used[l];
    endfunction

    function int unsigned place(int unsigned l);
      int unsigned c;
      c          = filled;
      cell_of[l] = c;
      used[l]    = 1'b1;
      filled     = c + 1;
      return c;
    endfunction

    function void owe_cell(int unsigned l, int unsigned c);
      cell_report_t r;
      r.letter = ckey_pkg::letter_t'(l);
      r.row    = ckey_pkg::pos_t'(c / ckey_pkg::Side);
      r.col    = ckey_pkg::pos_t'(c % ckey_pkg::Side);
      r.last   = 1'b0;
      pending.push_back(r);
    endfunction

    function void note_input(ckey_pkg::action_e act, ckey_pkg::letter_t a,
                             ckey_pkg::letter_t b);
      int unsigned  la;
      int unsigned  lb;
      int unsigned  l;
      int           prev_size;
      bit           ha;
      bit           hb;
      cell_report_t r;
      la        = a;
      lb        = b;
      prev_size = pending.size();
      n_inputs++;
      case (act)
        ckey_pkg::ACT_ADD: begin
          if (la < ckey_pkg::Letters && la != ckey_pkg::LetterJ && !placed(la)
              && filled < ckey_pkg::Cells)
            owe_cell(la, place(la));
        end
        ckey_pkg::ACT_FILL: begin
          for (l = 0; l < ckey_pkg::Letters && filled < ckey_pkg::Cells; l++) begin
            if (l != ckey_pkg::LetterJ && !used[l]) owe_cell(l, place(l));
          end
        end
        ckey_pkg::ACT_LOOKUP: begin
          ha = placed(la);
          hb = placed(lb) && lb != la;
          if (ha && hb) begin
            // reported in square order, not request order
            if (cell_of[la] <= cell_of[lb]) begin
              owe_cell(la, cell_of[la]);
              owe_cell(lb, cell_of[lb]);
            end else begin
              owe_cell(lb, cell_of[lb]);
              owe_cell(la, cell_of[la]);
            end
          end else if (ha) begin
            owe_cell(la, cell_of[la]);
          end else if (hb) begin
            owe_cell(lb, cell_of[lb]);
          end
        end
        default: ;
      endcase
      if (pending.size() > prev_size) begin
        r      = pending.pop_back();
        r.last = 1'b1;
        pending.push_back(r);
        if (pending.size() - prev_size > max_burst) max_burst = pending.size() - prev_size;
      end
    endfunction

    task check_result(ckey_pkg::letter_t l, ckey_pkg::pos_t rw, ckey_pkg::pos_t cl,
                      logic lst);
      cell_report_t e;
      n_results++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result letter %0d row %0d col %0d", l, rw, cl));
      end else begin
        e = pending.pop_front();
        if (l !== e.letter)
          report($sformatf("letter got %0d want %0d", l, e.letter));
        if (rw !== e.row)
          report($sformatf("row of letter %0d got %0d want %0d", e.letter, rw, e.row));
        if (cl !== e.col)
          report($sformatf("column of letter %0d got %0d want %0d", e.letter, cl, e.col));
        if (lst !== e.last)
          report($sformatf("tlast of letter %0d got %0b want %0b", e.letter, lst, e.last));
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [15:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  key_square_scoreboard sb;
  int src_idle_pct;
  int snk_idle_pct;
  int hold_cycles;

  cipher_key_square_builder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #12_000_000;
    $display("simulation failed");
    $finish;
  end

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin
    m_axis_tready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
        sb.check_result(m_axis_tdata_o[4:0], m_axis_tdata_o[7:5], m_axis_tdata_o[10:8],
                        m_axis_tlast_o);
    end
  end

  function automatic ckey_pkg::letter_t rand_letter();
    if ($urandom_range(99) < 88) return ckey_pkg::letter_t'($urandom_range(25));
    return ckey_pkg::letter_t'($urandom_range(31, 26));
  endfunction

  task automatic send_item(ckey_pkg::action_e act, ckey_pkg::letter_t a,
                           ckey_pkg::letter_t b);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'b0000, b, a, act};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_input(act, a, b);
  endtask

  // key building first, later mostly lookups on the finished square
  task automatic send_mixed(bit building);
    int unsigned pick;
    pick = $urandom_range(99);
    if (building) begin
      if (pick < 70)
        send_item(ckey_pkg::ACT_ADD, rand_letter(), ckey_pkg::letter_t'($urandom_range(31)));
      else if (pick < 88)
        send_item(ckey_pkg::ACT_LOOKUP, rand_letter(), rand_letter());
      else
        send_item(ckey_pkg::ACT_NONE, rand_letter(), ckey_pkg::letter_t'($urandom_range(31)));
    end else begin
      if (pick < 75)
        send_item(ckey_pkg::ACT_LOOKUP, rand_letter(), rand_letter());
      else if (pick < 85)
        send_item(ckey_pkg::ACT_ADD, rand_letter(), ckey_pkg::letter_t'($urandom_range(31)));
      else if (pick < 93)
        send_item(ckey_pkg::ACT_FILL, rand_letter(), ckey_pkg::letter_t'($urandom_range(31)));
      else
        send_item(ckey_pkg::ACT_NONE, rand_letter(), ckey_pkg::letter_t'($urandom_range(31)));
    end
  endtask

  initial begin
    int idx;
    sb              = new();
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    src_idle_pct    = 34;
    snk_idle_pct    = 74;
    hold_cycles     = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty square, dropped letters, repeats and lookup corner cases
    send_item(ckey_pkg::ACT_LOOKUP, 5'd0, 5'd25);
    send_item(ckey_pkg::ACT_NONE, 5'd31, 5'd31);
    send_item(ckey_pkg::ACT_ADD, ckey_pkg::letter_t'(ckey_pkg::LetterJ), 5'd0);
    send_item(ckey_pkg::ACT_ADD, 5'd31, 5'd0);
    send_item(ckey_pkg::ACT_ADD, 5'd26, 5'd0);
    send_item(ckey_pkg::ACT_ADD, 5'd0, 5'd0);
    send_item(ckey_pkg::ACT_ADD, 5'd0, 5'd31);
    send_item(ckey_pkg::ACT_ADD, 5'd25, 5'd31);
    send_item(ckey_pkg::ACT_ADD, 5'd16, 5'd10);
    send_item(ckey_pkg::ACT_LOOKUP, 5'd25, 5'd0);
    send_item(ckey_pkg::ACT_LOOKUP, 5'd0, 5'd25);
    send_item(ckey_pkg::ACT_LOOKUP, 5'd16, 5'd16);
    send_item(ckey_pkg::ACT_LOOKUP, ckey_pkg::letter_t'(ckey_pkg::LetterJ), 5'd25);
    send_item(ckey_pkg::ACT_LOOKUP, 5'd3, 5'd30);
    send_item(ckey_pkg::ACT_LOOKUP, 5'd31, 5'd0);
    send_item(ckey_pkg::ACT_LOOKUP, 5'd0, 5'd3);
    send_item(ckey_pkg::ACT_ADD, 5'd15, 5'd16);
    send_item(ckey_pkg::ACT_NONE, 5'd0, 5'd0);

    for (idx = 0; idx < 500; idx++) begin
      if (idx == 167) begin
        src_idle_pct = 74;
        snk_idle_pct = 34;
      end
      if (idx == 334) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_cycles  = 300;
      end
      if (idx == 40)
        send_item(ckey_pkg::ACT_FILL, rand_letter(), ckey_pkg::letter_t'($urandom_range(31)));
      else
        send_mixed(idx < 40);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("covered %0d input transfers and %0d result transfers, %0d of %0d cells placed",
             sb.n_inputs, sb.n_results, sb.filled, ckey_pkg::Cells);
    $display("largest burst from one transfer: %0d results, %0d mismatches",
             sb.max_burst, sb.errors);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/ckey_pkg.sv
sv/ckey_mem.sv
sv/ckey_ctrl.sv
sv/cipher_key_square_builder.sv
sv/ckey_checker.sv
tb/tb.sv
